/* hdl/fpn_pkg.sv */
// Shared types and constants for the frame peak normalizer.
package fpn_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 4 * CHAN_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;
    localparam int DIVIDEND_W = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] FULL_LEVEL = 8'd255;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_NORM  = 2'd2;

    // result kinds
    localparam logic RK_PIXEL = 1'b0;
    localparam logic RK_PEAK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CHAN_W-1:0] x_coord;
        logic [CHAN_W-1:0] y_coord;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic [CHAN_W-1:0] peak_level;
    } t_out_item;

endpackage

/* hdl/frame_peak_normalizer_top.sv */
// Frame peak normalizer: RGBA frame store with read, write and global-peak contrast stretch.
//
// The block holds a MAX_WIDTH x MAX_HEIGHT frame of 32-bit RGBA pixels in one
// RAM, addressed y*MAX_WIDTH+x. After reset a clearing pass writes zero to
// every entry, one per cycle; no item is taken until it ends, while
// configuration writes are taken at any time. A write item leaves the block
// ready, so the next item can follow in the next cycle. A read item passes
// through RAM read, capture and hand-off to the output register; the hand-off
// waits while the output register holds an untaken result. A normalize item
// walks the active frame twice. The first walk streams one pixel per cycle
// through the peak compare. The second walk reads each pixel, runs its red,
// green and blue channels one after another through the single shared 8-step
// restoring divider (c*255/peak) and writes the pixel back with alpha 255.
// A peak of zero skips the divider and writes zero colour channels.
// Coordinates outside the active frame make writes vanish and reads return
// zero. Results sit in an output register, so a write item can be taken while
// a result still waits for the consumer.
module frame_peak_normalizer_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fpn_pkg::t_in_item              i_in_item,
    // result output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fpn_pkg::t_out_item             o_out_item,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpn_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW_X  = $clog2(MAX_WIDTH + 1);
    localparam int CW_Y  = $clog2(MAX_HEIGHT + 1);
    localparam int CHW   = fpn_pkg::CHAN_W;
    localparam int PXW   = fpn_pkg::PIXEL_W;
    localparam logic [1:0] LAST_CH = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_DELIVER,
        S_SCAN,
        S_SCAN_END,
        S_NRM_RD,
        S_NRM_WAIT,
        S_NRM_DIV,
        S_NRM_WR
    } t_state;

    t_state                         r_state;
    logic [fpn_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [fpn_pkg::CFG_DATA_W-1:0] r_frame_height;
    logic [AW-1:0]                  r_clr_addr;
    logic [CW_X-1:0]                r_cx;
    logic [CW_Y-1:0]                r_cy;
    logic [AW-1:0]                  r_row_base;
    logic [CHW-1:0]                 r_peak;
    logic                           r_scan_vld;
    logic                           r_rd_in;
    logic [PXW-1:0]                 r_pix;
    logic [3*CHW-1:0]               r_newpix;
    logic [1:0]                     r_ch;
    fpn_pkg::t_out_item             r_res;
    logic                           r_out_valid;
    fpn_pkg::t_out_item             r_out;

    logic [CW_X-1:0]  w_cols;
    logic [CW_Y-1:0]  w_rows;
    logic             w_accept;
    logic             w_io_in;
    logic [AW-1:0]    w_io_addr;
    logic [AW-1:0]    w_walk_addr;
    logic             w_last_col;
    logic             w_last_pix;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [PXW-1:0]   w_wr_data;
    logic [AW-1:0]    w_rd_addr;
    logic [PXW-1:0]   w_rd_data;
    logic [CHW-1:0]   w_max_rg;
    logic [CHW-1:0]   w_max_rgb;
    logic [CHW-1:0]   w_peak_nxt;
    logic             w_div_start;
    logic [CHW-1:0]   w_div_chan;
    logic [fpn_pkg::DIVIDEND_W-1:0] w_dividend;
    logic             w_div_done;
    logic [CHW-1:0]   w_div_q;
    logic [1:0]       w_ch_next;

    // active frame size, saturated at the store bounds
    assign w_cols = (int'(r_frame_width) > MAX_WIDTH) ? CW_X'(MAX_WIDTH)
                                                      : CW_X'(r_frame_width);
    assign w_rows = (int'(r_frame_height) > MAX_HEIGHT) ? CW_Y'(MAX_HEIGHT)
                                                        : CW_Y'(r_frame_height);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_io_in   = (int'(i_in_item.x_coord) < int'(w_cols)) &&
                       (int'(i_in_item.y_coord) < int'(w_rows));
    assign w_io_addr = AW'(int'(i_in_item.y_coord) * MAX_WIDTH + int'(i_in_item.x_coord));

    // walk position: running row base plus column
    assign w_walk_addr = r_row_base + AW'(r_cx);
    assign w_last_col  = (r_cx == w_cols - CW_X'(1));
    assign w_last_pix  = w_last_col && (r_cy == w_rows - CW_Y'(1));

    // RAM port steering
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_walk_addr;
        w_wr_data = {fpn_pkg::FULL_LEVEL, r_newpix};
        w_rd_addr = w_walk_addr;
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
            end
            S_IDLE: begin
                w_rd_addr = w_io_addr;
                w_wr_addr = w_io_addr;
                w_wr_data = {i_in_item.alpha_in, i_in_item.blue_in,
                             i_in_item.green_in, i_in_item.red_in};
                w_wr_en   = w_accept && (i_in_item.operation == fpn_pkg::OP_WRITE) && w_io_in;
            end
            S_NRM_WR: begin
                w_wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    fpn_ram #(
        .WIDTH (PXW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // peak compare over red, green, blue
    always_comb begin
        w_max_rg   = (w_rd_data[7:0] > w_rd_data[15:8]) ? w_rd_data[7:0] : w_rd_data[15:8];
        w_max_rgb  = (w_max_rg > w_rd_data[23:16]) ? w_max_rg : w_rd_data[23:16];
        w_peak_nxt = (w_max_rgb > r_peak) ? w_max_rgb : r_peak;
    end

    // divider feed: channel 0 straight from RAM, later channels from the held pixel
    assign w_ch_next = r_ch + 2'd1;
    always_comb begin
        if (r_state == S_NRM_WAIT) begin
            w_div_chan  = w_rd_data[CHW-1:0];
            w_div_start = (r_peak != '0);
        end else begin
            w_div_chan  = r_pix[CHW*w_ch_next +: CHW];
            w_div_start = (r_state == S_NRM_DIV) && w_div_done && (r_ch != LAST_CH);
        end
        // c*255 as c*256 - c
        w_dividend = {w_div_chan, {CHW{1'b0}}} - {{CHW{1'b0}}, w_div_chan};
    end

    fpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_peak),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_frame_width  <= fpn_pkg::FRAME_DIM_RESET;
            r_frame_height <= fpn_pkg::FRAME_DIM_RESET;
            r_peak         <= '0;
            r_scan_vld     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cx           <= '0;
            r_cy           <= '0;
            r_row_base     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fpn_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    fpn_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // in S_DELIVER the hand-off below owns the valid flag
            if (r_out_valid && i_out_ready && (r_state != S_DELIVER)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_item.operation)
                            fpn_pkg::OP_READ: begin
                                r_rd_in <= w_io_in;
                                r_state <= S_RD_WAIT;
                            end
                            fpn_pkg::OP_NORM: begin
                                r_peak     <= '0;
                                r_cx       <= '0;
                                r_cy       <= '0;
                                r_row_base <= '0;
                                r_scan_vld <= 1'b0;
                                if (w_cols == '0 || w_rows == '0) begin
                                    r_res   <= '{fpn_pkg::RK_PEAK, '0, '0, '0, '0, '0};
                                    r_state <= S_DELIVER;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_res.result_kind <= fpn_pkg::RK_PIXEL;
                    r_res.red_out     <= r_rd_in ? w_rd_data[7:0]   : '0;
                    r_res.green_out   <= r_rd_in ? w_rd_data[15:8]  : '0;
                    r_res.blue_out    <= r_rd_in ? w_rd_data[23:16] : '0;
                    r_res.alpha_out   <= r_rd_in ? w_rd_data[31:24] : '0;
                    r_res.peak_level  <= '0;
                    r_state           <= S_DELIVER;
                end
                S_DELIVER: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_scan_vld) begin
                        r_peak <= w_peak_nxt;
                    end
                    r_scan_vld <= 1'b1;
                    if (w_last_pix) begin
                        r_cx       <= '0;
                        r_cy       <= '0;
                        r_row_base <= '0;
                        r_state    <= S_SCAN_END;
                    end else if (w_last_col) begin
                        r_cx       <= '0;
                        r_cy       <= r_cy + CW_Y'(1);
                        r_row_base <= r_row_base + AW'(MAX_WIDTH);
                    end else begin
                        r_cx <= r_cx + CW_X'(1);
                    end
                end
                S_SCAN_END: begin
                    // last pixel read lands here
                    r_peak     <= w_peak_nxt;
                    r_scan_vld <= 1'b0;
                    r_state    <= S_NRM_RD;
                end
                S_NRM_RD: begin
                    r_state <= S_NRM_WAIT;
                end
                S_NRM_WAIT: begin
                    r_pix <= w_rd_data;
                    r_ch  <= '0;
                    if (r_peak == '0) begin
                        r_newpix <= '0;
                        r_state  <= S_NRM_WR;
                    end else begin
                        r_state <= S_NRM_DIV;
                    end
                end
                S_NRM_DIV: begin
                    if (w_div_done) begin
                        r_newpix[CHW*r_ch +: CHW] <= w_div_q;
                        if (r_ch == LAST_CH) begin
                            r_state <= S_NRM_WR;
                        end else begin
                            r_ch <= w_ch_next;
                        end
                    end
                end
                S_NRM_WR: begin
                    if (w_last_pix) begin
                        r_cx       <= '0;
                        r_cy       <= '0;
                        r_row_base <= '0;
                        r_res      <= '{fpn_pkg::RK_PEAK, '0, '0, '0, '0, r_peak};
                        r_state    <= S_DELIVER;
                    end else begin
                        if (w_last_col) begin
                            r_cx       <= '0;
                            r_cy       <= r_cy + CW_Y'(1);
                            r_row_base <= r_row_base + AW'(MAX_WIDTH);
                        end else begin
                            r_cx <= r_cx + CW_X'(1);
                        end
                        r_state <= S_NRM_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* hdl/fpn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/fpn_div.sv */
// Restoring divider, one quotient bit per cycle; quotient must fit in CHAN_W bits.
module fpn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fpn_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [fpn_pkg::CHAN_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [fpn_pkg::CHAN_W-1:0]     o_quotient
);

    localparam int CW          = fpn_pkg::CHAN_W;
    localparam int SW          = $clog2(CW);
    localparam int DIVIDEND_HI = fpn_pkg::DIVIDEND_W - 1;

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_low;
    logic [CW-1:0] r_quo;

    logic [CW:0]   w_trial;
    logic [CW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_trial = {r_rem, r_low[CW-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // high half is below the divisor, so start from it directly
                r_rem  <= i_dividend[DIVIDEND_HI:CW];
                r_low  <= i_dividend[CW-1:0];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
                r_low <= {r_low[CW-2:0], 1'b0};
                r_quo <= {r_quo[CW-2:0], w_ge};
                r_cnt <= r_cnt + SW'(1);
                if (r_cnt == SW'(CW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/fpn_checker.sv */
// Port-level checks for the frame peak normalizer, bound to the top level.
module fpn_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input fpn_pkg::t_in_item              i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input fpn_pkg::t_out_item             o_out_item
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    // reset starts the clearing pass, so no item is taken right after it
    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item channel ready during clearing pass");

    // a write leaves the block ready for the next item
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_item.operation == fpn_pkg::OP_WRITE)
        |=> o_in_ready)
        else $error("write item held the block busy");

    // reads and normalizes do not leave the block ready, unlike writes
    a_long_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        ((i_in_item.operation == fpn_pkg::OP_READ) ||
         (i_in_item.operation == fpn_pkg::OP_NORM))
        |=> !o_in_ready)
        else $error("ready returned too early after read or normalize");

    // pixel results carry no peak, peak results carry no pixel
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_out_item.result_kind == fpn_pkg::RK_PIXEL) && (o_out_item.peak_level == '0)) ||
        ((o_out_item.result_kind == fpn_pkg::RK_PEAK) && (o_out_item.red_out == '0) &&
         (o_out_item.green_out == '0) && (o_out_item.blue_out == '0) &&
         (o_out_item.alpha_out == '0)))
        else $error("result fields do not match result kind");

endmodule

bind frame_peak_normalizer_top fpn_checker u_fpn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
